// ===== hdl/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types, character codes and defaults of the table driven lexer.
// ----------------------------------------------------------------------------
package tdl_pkg;

    // default configuration
    localparam int MATCH_LEN_DEF     = 6;
    localparam int TABLE_ENTRIES_DEF = 4;
    localparam int POSITION_BITS_DEF = 16;

    // configuration port and table entry layout
    localparam int CFG_W        = 60;
    localparam int CFG_IDX_W    = 3;
    localparam int N_TABLES     = 2;
    localparam int N_ENTRIES    = 4;
    localparam int ENT_LEN_LSB  = 48;
    localparam int ENT_TYPE_LSB = 52;
    localparam int OUT_TDATA_W  = 48;

    // character codes
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
    localparam logic [7:0] CH_UPPER_LO   = 8'h41;
    localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO   = 8'h61;
    localparam logic [7:0] CH_LOWER_HI   = 8'h7A;

    typedef enum logic [2:0] {
        TOK_NEWLINE  = 3'd0,
        TOK_BLANK    = 3'd1,
        TOK_OPERATOR = 3'd2,
        TOK_KEYWORD  = 3'd3,
        TOK_IDENT    = 3'd4,
        TOK_NUMBER   = 3'd5,
        TOK_END      = 3'd6
    } token_type_t;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_BLANK  = 2'd1,
        RUN_IDENT  = 2'd2,
        RUN_NUMBER = 2'd3
    } run_kind_t;

    typedef enum logic [1:0] {
        SCAN_NONE = 2'd0,
        SCAN_HIT  = 2'd1,
        SCAN_WAIT = 2'd2
    } scan_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DECIDE = 2'd1,
        PH_CLOSE  = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    // byte class worked out by the front end
    typedef struct packed {
        logic lf;
        logic cr;
        logic blank;
        logic digit;
        logic id_start;
    } chclass_t;

    typedef struct packed {
        logic [7:0] ch;
        chclass_t   cls;
        logic       last;
    } in_item_t;

    typedef struct packed {
        token_type_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  utype;
        logic        too_long;
    } tok_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } out_item_t;

    function automatic token_type_t run_token(input run_kind_t k);
        token_type_t t;
        unique case (k)
            RUN_BLANK: t = TOK_BLANK;
            RUN_IDENT: t = TOK_IDENT;
            RUN_NUMBER: t = TOK_NUMBER;
            RUN_NONE: t = TOK_NUMBER;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/tdl_fifo.sv =====
// ----------------------------------------------------------------------------
// tdl_fifo
// Small register queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module tdl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg < CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/tdl_front.sv =====
// ----------------------------------------------------------------------------
// tdl_front
// Takes text bytes, classifies each one and queues it for the back end.
// ----------------------------------------------------------------------------
module tdl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_ch,
    input  logic               s_last,
    output logic               q_valid,
    input  logic               q_ready,
    output tdl_pkg::in_item_t  q_item
);
    tdl_pkg::in_item_t item;

    // byte classification
    always_comb begin
        item.ch           = s_ch;
        item.last         = s_last;
        item.cls.lf       = (s_ch == tdl_pkg::CH_LF);
        item.cls.cr       = (s_ch == tdl_pkg::CH_CR);
        item.cls.blank    = (s_ch == tdl_pkg::CH_SPACE) || (s_ch == tdl_pkg::CH_TAB);
        item.cls.digit    = (s_ch >= tdl_pkg::CH_DIGIT_LO) && (s_ch <= tdl_pkg::CH_DIGIT_HI);
        item.cls.id_start = ((s_ch >= tdl_pkg::CH_UPPER_LO) && (s_ch <= tdl_pkg::CH_UPPER_HI))
                         || ((s_ch >= tdl_pkg::CH_LOWER_LO) && (s_ch <= tdl_pkg::CH_LOWER_HI))
                         || (s_ch == tdl_pkg::CH_UNDERSCORE);
    end

    // queue towards the back end
    tdl_fifo #(
        .WIDTH ($bits(tdl_pkg::in_item_t)),
        .DEPTH (2)
    ) u_in_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

endmodule

// ===== hdl/tdl_back.sv =====
// ----------------------------------------------------------------------------
// tdl_back
// Look-ahead window, table match and run tracking; one decision per cycle while not stalled.
// ----------------------------------------------------------------------------
module tdl_back #(
    parameter int MATCH_LEN     = tdl_pkg::MATCH_LEN_DEF,
    parameter int TABLE_ENTRIES = tdl_pkg::TABLE_ENTRIES_DEF,
    parameter int POSITION_BITS = tdl_pkg::POSITION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tdl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdl_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tdl_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tdl_pkg::out_item_t            out_item
);
    localparam int WIN_DEPTH = MATCH_LEN + 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int P         = POSITION_BITS;

    typedef struct packed {
        logic [7:0]        ch;
        tdl_pkg::chclass_t cls;
    } win_ent_t;

    // state
    win_ent_t             win_reg [WIN_DEPTH];
    win_ent_t             win_next [WIN_DEPTH];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [P-1:0]         pos_reg, pos_next;
    logic [P-1:0]         rstart_reg, rstart_next;
    tdl_pkg::run_kind_t   rkind_reg, rkind_next;
    logic                 ovf_reg, ovf_next;
    logic                 ended_reg, ended_next;
    tdl_pkg::phase_t      phase_reg, phase_next;
    logic [tdl_pkg::CFG_W-1:0] tbl_reg [tdl_pkg::N_TABLES][tdl_pkg::N_ENTRIES];
    tdl_pkg::tok_t        hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 hold_final_reg, hold_final_next;

    // working view of the state for this cycle
    win_ent_t             cur_win [WIN_DEPTH];
    logic [FILL_W-1:0]    cur_fill;
    logic [P-1:0]         cur_pos;
    logic                 cur_ovf;
    logic                 cur_ended;
    logic [P-1:0]         hp;

    tdl_pkg::scan_t       sres [tdl_pkg::N_TABLES];
    logic [3:0]           slen [tdl_pkg::N_TABLES];
    logic [7:0]           sut  [tdl_pkg::N_TABLES];

    logic                 dec_tok_v;
    tdl_pkg::tok_t        dec_tok;
    logic [FILL_W-1:0]    dec_cons;
    tdl_pkg::run_kind_t   dec_rk;
    logic [P-1:0]         dec_rs;
    logic                 dec_brk;
    logic [FILL_W-1:0]    dec_fill;
    logic                 dec_done;

    logic                 step_tok_v;
    tdl_pkg::tok_t        step_tok;
    logic                 step_fin;
    logic                 go;
    logic                 push, push_last;

    assign go        = ((phase_reg == tdl_pkg::PH_IDLE) ? in_valid : 1'b1)
                    && (!hold_valid_reg || out_ready);
    assign in_ready  = go && (phase_reg == tdl_pkg::PH_IDLE);

    // table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < tdl_pkg::N_TABLES; t++) begin
                for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
                    tbl_reg[t][i] <= '0;
                end
            end
        end else if (cfg_wr_en) begin
            tbl_reg[cfg_index[2]][cfg_index[1:0]] <= cfg_wdata;
        end
    end

    // new byte enters the window at the start of a step
    always_comb begin
        cur_win   = win_reg;
        cur_fill  = fill_reg;
        cur_pos   = pos_reg;
        cur_ovf   = ovf_reg;
        cur_ended = ended_reg;
        if (phase_reg == tdl_pkg::PH_IDLE) begin
            cur_ended = in_item.last;
            if (&pos_reg) begin
                cur_ovf = 1'b1;
            end else begin
                cur_pos = pos_reg + 1'b1;
            end
            if (fill_reg < FILL_W'(WIN_DEPTH)) begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    if (FILL_W'(k) == fill_reg) begin
                        cur_win[k] = {in_item.ch, in_item.cls};
                    end
                end
                cur_fill = fill_reg + 1'b1;
            end
        end
    end

    assign hp = (cur_pos >= P'(cur_fill)) ? cur_pos - P'(cur_fill) : '0;

    // operator and keyword tables, compared in parallel at the window head
    always_comb begin
        logic [tdl_pkg::CFG_W-1:0] e;
        logic [3:0]                l;
        logic                      mism;
        logic                      stop;
        for (int t = 0; t < tdl_pkg::N_TABLES; t++) begin
            sres[t] = tdl_pkg::SCAN_NONE;
            slen[t] = '0;
            sut[t]  = '0;
            stop    = 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                e    = tbl_reg[t][i];
                l    = e[tdl_pkg::ENT_LEN_LSB +: 4];
                mism = 1'b0;
                for (int j = 0; j < MATCH_LEN; j++) begin
                    if ((4'(j) < l) && (FILL_W'(j) < cur_fill)
                            && (cur_win[j].ch != e[8*j +: 8])) begin
                        mism = 1'b1;
                    end
                end
                if (!stop) begin
                    if (l == 4'd0) begin
                        stop = 1'b1;
                    end else if ((l <= 4'(MATCH_LEN)) && !mism) begin
                        if (l > 4'(cur_fill)) begin
                            if (!cur_ended) begin
                                sres[t] = tdl_pkg::SCAN_WAIT;
                                stop    = 1'b1;
                            end
                        end else begin
                            sres[t] = tdl_pkg::SCAN_HIT;
                            slen[t] = l;
                            sut[t]  = e[tdl_pkg::ENT_TYPE_LSB +: 8];
                            stop    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // one decision on the window head
    always_comb begin
        logic cont;
        dec_tok_v         = 1'b0;
        dec_tok.kind      = tdl_pkg::TOK_NEWLINE;
        dec_tok.start     = 16'(hp);
        dec_tok.length    = 16'd1;
        dec_tok.utype     = '0;
        dec_tok.too_long  = cur_ovf;
        dec_cons          = '0;
        dec_rk            = rkind_reg;
        dec_rs            = rstart_reg;
        dec_brk           = 1'b0;
        unique case (rkind_reg)
            tdl_pkg::RUN_BLANK:  cont = cur_win[0].cls.blank;
            tdl_pkg::RUN_IDENT:  cont = cur_win[0].cls.id_start || cur_win[0].cls.digit;
            tdl_pkg::RUN_NUMBER: cont = cur_win[0].cls.digit;
            tdl_pkg::RUN_NONE:   cont = 1'b0;
        endcase
        priority if (cur_fill == '0) begin
            dec_brk = 1'b1;
        end else if (rkind_reg != tdl_pkg::RUN_NONE) begin
            if (cont) begin
                dec_cons = FILL_W'(1);
            end else begin
                dec_tok_v      = 1'b1;
                dec_tok.kind   = tdl_pkg::run_token(rkind_reg);
                dec_tok.start  = 16'(rstart_reg);
                dec_tok.length = 16'((hp >= rstart_reg) ? hp - rstart_reg : '0);
                dec_rk         = tdl_pkg::RUN_NONE;
            end
        end else if (cur_win[0].cls.lf) begin
            dec_tok_v = 1'b1;
            dec_cons  = FILL_W'(1);
        end else if (cur_win[0].cls.cr) begin
            if (cur_fill >= FILL_W'(2)) begin
                dec_tok_v = 1'b1;
                if (cur_win[1].cls.lf) begin
                    dec_tok.length = 16'd2;
                    dec_cons       = FILL_W'(2);
                end else begin
                    dec_cons = FILL_W'(1);
                end
            end else if (cur_ended) begin
                dec_tok_v = 1'b1;
                dec_cons  = FILL_W'(1);
            end else begin
                dec_brk = 1'b1;
            end
        end else if (cur_win[0].cls.blank) begin
            dec_rk   = tdl_pkg::RUN_BLANK;
            dec_rs   = hp;
            dec_cons = FILL_W'(1);
        end else if (sres[0] == tdl_pkg::SCAN_WAIT) begin
            dec_brk = 1'b1;
        end else if (sres[0] == tdl_pkg::SCAN_HIT) begin
            dec_tok_v      = 1'b1;
            dec_tok.kind   = tdl_pkg::TOK_OPERATOR;
            dec_tok.length = 16'(slen[0]);
            dec_tok.utype  = sut[0];
            dec_cons       = FILL_W'(slen[0]);
        end else if (sres[1] == tdl_pkg::SCAN_WAIT) begin
            dec_brk = 1'b1;
        end else if (sres[1] == tdl_pkg::SCAN_HIT) begin
            dec_tok_v      = 1'b1;
            dec_tok.kind   = tdl_pkg::TOK_KEYWORD;
            dec_tok.length = 16'(slen[1]);
            dec_tok.utype  = sut[1];
            dec_cons       = FILL_W'(slen[1]);
        end else begin
            if (cur_win[0].cls.id_start) begin
                dec_rk = tdl_pkg::RUN_IDENT;
                dec_rs = hp;
            end else if (cur_win[0].cls.digit) begin
                dec_rk = tdl_pkg::RUN_NUMBER;
                dec_rs = hp;
            end
            dec_cons = FILL_W'(1);
        end
    end

    assign dec_fill = cur_fill - dec_cons;
    assign dec_done = dec_brk || (dec_fill == '0);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            tdl_pkg::PH_IDLE, tdl_pkg::PH_DECIDE: begin
                if (go) begin
                    if (!dec_done) begin
                        phase_next = tdl_pkg::PH_DECIDE;
                    end else if (!cur_ended) begin
                        phase_next = tdl_pkg::PH_IDLE;
                    end else if (dec_rk != tdl_pkg::RUN_NONE) begin
                        phase_next = tdl_pkg::PH_CLOSE;
                    end else begin
                        phase_next = tdl_pkg::PH_END;
                    end
                end
            end
            tdl_pkg::PH_CLOSE: if (go) phase_next = tdl_pkg::PH_END;
            tdl_pkg::PH_END:   if (go) phase_next = tdl_pkg::PH_IDLE;
        endcase
    end

    // token of this cycle per phase
    always_comb begin
        step_tok_v          = 1'b0;
        step_tok            = dec_tok;
        step_fin            = 1'b0;
        unique case (phase_reg)
            tdl_pkg::PH_IDLE, tdl_pkg::PH_DECIDE: begin
                step_tok_v = dec_tok_v;
                step_fin   = dec_done && !cur_ended;
            end
            tdl_pkg::PH_CLOSE: begin
                step_tok_v        = 1'b1;
                step_tok.kind     = tdl_pkg::run_token(rkind_reg);
                step_tok.start    = 16'(rstart_reg);
                step_tok.length   = 16'((pos_reg >= rstart_reg) ? pos_reg - rstart_reg : '0);
                step_tok.utype    = '0;
                step_tok.too_long = ovf_reg;
            end
            tdl_pkg::PH_END: begin
                step_tok_v        = 1'b1;
                step_tok.kind     = tdl_pkg::TOK_END;
                step_tok.start    = 16'(pos_reg);
                step_tok.length   = '0;
                step_tok.utype    = '0;
                step_tok.too_long = ovf_reg;
                step_fin          = 1'b1;
            end
        endcase
    end

    // text state update
    always_comb begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        rstart_next = rstart_reg;
        rkind_next  = rkind_reg;
        ovf_next    = ovf_reg;
        ended_next  = ended_reg;
        if (go) begin
            unique case (phase_reg)
                tdl_pkg::PH_IDLE, tdl_pkg::PH_DECIDE: begin
                    for (int m = 0; m < WIN_DEPTH; m++) begin
                        win_next[m] = cur_win[m];
                        for (int s = 1; s <= WIN_DEPTH; s++) begin
                            if ((dec_cons == FILL_W'(s)) && (m + s < WIN_DEPTH)) begin
                                win_next[m] = cur_win[(m + s) % WIN_DEPTH];
                            end
                        end
                    end
                    fill_next   = dec_fill;
                    pos_next    = cur_pos;
                    ovf_next    = cur_ovf;
                    ended_next  = cur_ended;
                    rkind_next  = dec_rk;
                    rstart_next = dec_rs;
                end
                tdl_pkg::PH_CLOSE: rkind_next = tdl_pkg::RUN_NONE;
                tdl_pkg::PH_END: begin
                    fill_next   = '0;
                    pos_next    = '0;
                    rstart_next = '0;
                    rkind_next  = tdl_pkg::RUN_NONE;
                    ovf_next    = 1'b0;
                    ended_next  = 1'b0;
                end
            endcase
        end
    end

    // hold stage: a token leaves once it is known whether it ends its byte's results
    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        if (hold_valid_reg && hold_final_reg && out_ready) begin
            push            = 1'b1;
            push_last       = 1'b1;
            hold_valid_next = 1'b0;
        end
        if (go) begin
            if (hold_valid_reg && !hold_final_reg) begin
                if (step_tok_v) begin
                    push = 1'b1;
                end else if (step_fin) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
            if (step_tok_v) begin
                hold_next       = step_tok;
                hold_valid_next = 1'b1;
                hold_final_next = step_fin;
            end
        end
    end

    assign out_valid     = push;
    assign out_item.tok  = hold_reg;
    assign out_item.last = push_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            pos_reg        <= '0;
            rstart_reg     <= '0;
            rkind_reg      <= tdl_pkg::RUN_NONE;
            ovf_reg        <= 1'b0;
            ended_reg      <= 1'b0;
            phase_reg      <= tdl_pkg::PH_IDLE;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            rstart_reg     <= rstart_next;
            rkind_reg      <= rkind_next;
            ovf_reg        <= ovf_next;
            ended_reg      <= ended_next;
            phase_reg      <= phase_next;
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        hold_reg <= hold_next;
    end

endmodule

// ===== hdl/table_driven_lexer.sv =====
// ----------------------------------------------------------------------------
// table_driven_lexer
// Streaming lexer: bytes in, newline, blank, operator, keyword, identifier,
// number and end tokens out.
// ----------------------------------------------------------------------------
// Text enters one byte per word with tlast on its last byte; the block takes
// a byte every cycle while the back end keeps up. The back end makes one
// decision on the head of its look-ahead window per cycle while not stalled,
// the first in the same cycle as the byte arrives, and hands out at most one
// token per cycle. Extending, starting or skipping a run, or completing a
// newline, operator or keyword token is one decision; closing an open run is
// a decision of its own, taken before the closing byte is decided; bytes held
// back for a table compare are released one decision a cycle while not
// stalled (a whole table match in one), and the end of a text adds a decision
// for an open last run and one for the end token. tlast on the result side
// marks the last token caused by an input byte. The user must write the eight
// table entries through the cfg port (indices 0 to 3 operators, 4 to 7
// keywords) only while no text is in flight; the block does not enforce it.
module table_driven_lexer #(
    parameter int MATCH_LEN     = tdl_pkg::MATCH_LEN_DEF,
    parameter int TABLE_ENTRIES = tdl_pkg::TABLE_ENTRIES_DEF,
    parameter int POSITION_BITS = tdl_pkg::POSITION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdl_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] ch
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] token_start, [31:16] token_length, [39:32] user_type, [40] too_long
    output logic [tdl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // [2:0] token_type
    output logic                            m_axis_tlast
);
    logic               q_valid, q_ready;
    tdl_pkg::in_item_t  q_item;
    logic               bk_valid, bk_ready;
    tdl_pkg::out_item_t bk_item, oq_item;

    // classify and queue bytes
    tdl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_ch    (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // decide tokens
    tdl_back #(
        .MATCH_LEN     (MATCH_LEN),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    // output register stage
    tdl_fifo #(
        .WIDTH ($bits(tdl_pkg::out_item_t)),
        .DEPTH (2)
    ) u_out_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (bk_valid),
        .wr_ready (bk_ready),
        .wr_data  (bk_item),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (oq_item)
    );

    // word packing
    assign m_axis_tdata = {7'd0, oq_item.tok.too_long, oq_item.tok.utype,
                           oq_item.tok.length, oq_item.tok.start};
    assign m_axis_tuser = oq_item.tok.kind;
    assign m_axis_tlast = oq_item.last;

`ifndef SYNTHESIS
    // the end token is always the last token of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == tdl_pkg::TOK_END)) |-> m_axis_tlast)
        else $error("end token without tlast");

    // the end token carries no length
    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == tdl_pkg::TOK_END)) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("end token with non-zero length");

    // nothing leaves right after reset
    a_rst_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output word straight after reset");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the table driven lexer: texts are streamed in byte
// by byte, a behavioural lexer predicts up to eight tokens per byte, and each
// token word that leaves the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WDOG_LIMIT = 4000;
    localparam int WIN_D      = tdl_pkg::MATCH_LEN_DEF + 1;
    localparam int POS_SAT    = (1 << tdl_pkg::POSITION_BITS_DEF) - 1;
    localparam int CFG_OP0    = 0;
    localparam int CFG_KW0    = 4;
    localparam int TAIL_WAIT  = 20;

    typedef struct {
        tdl_pkg::token_type_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  utype;
        logic        too_long;
        logic        last;
    } token_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [tdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tdl_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [tdl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]                    m_axis_tuser;
    logic                          m_axis_tlast;

    table_driven_lexer dut (.*);

    // lexer model state
    logic [tdl_pkg::CFG_W-1:0] op_tbl [tdl_pkg::N_ENTRIES];
    logic [tdl_pkg::CFG_W-1:0] kw_tbl [tdl_pkg::N_ENTRIES];
    logic [7:0]                la_win [WIN_D];
    int                        la_fill;
    int                        byte_pos;
    int                        run_from;
    tdl_pkg::run_kind_t        open_run;
    logic                      pos_ovf;
    int                        step_count;

    token_t token_q [$];
    int     fail_count;
    int     bytes_sent;
    int     tokens_seen;
    int     src_idle_pct;
    int     snk_stall_pct;
    int     snk_hold;
    int     idle_cycles;

    // clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------ model
    function automatic logic is_digit_c(logic [7:0] c);
        return c >= tdl_pkg::CH_DIGIT_LO && c <= tdl_pkg::CH_DIGIT_HI;
    endfunction

    function automatic logic is_start_c(logic [7:0] c);
        return (c >= tdl_pkg::CH_UPPER_LO && c <= tdl_pkg::CH_UPPER_HI) ||
               (c >= tdl_pkg::CH_LOWER_LO && c <= tdl_pkg::CH_LOWER_HI) ||
               c == tdl_pkg::CH_UNDERSCORE;
    endfunction

    function automatic logic is_blank_c(logic [7:0] c);
        return c == tdl_pkg::CH_SPACE || c == tdl_pkg::CH_TAB;
    endfunction

    function automatic void add_token(tdl_pkg::token_type_t k, int st, int len,
                                      logic [7:0] ut);
        token_t t;
        if (step_count >= 8) return;
        t.kind = k;
        t.start = st[15:0];
        t.length = len[15:0];
        t.utype = ut;
        t.too_long = pos_ovf;
        t.last = 1'b0;
        token_q.insert(token_q.size(), t);
        step_count++;
    endfunction

    function automatic void drop_head(int k);
        if (k > la_fill) k = la_fill;
        for (int i = 0; i < WIN_D; i++)
            la_win[i] = (i + k < WIN_D) ? la_win[i + k] : la_win[i];
        la_fill -= k;
    endfunction

    function automatic tdl_pkg::token_type_t token_of_run(tdl_pkg::run_kind_t k);
        if (k == tdl_pkg::RUN_BLANK) return tdl_pkg::TOK_BLANK;
        if (k == tdl_pkg::RUN_IDENT) return tdl_pkg::TOK_IDENT;
        return tdl_pkg::TOK_NUMBER;
    endfunction

    function automatic void close_open_run(int at);
        add_token(token_of_run(open_run), run_from, at >= run_from ? at - run_from : 0, 8'd0);
        open_run = tdl_pkg::RUN_NONE;
    endfunction

    // first matching entry of one table at the window head
    function automatic tdl_pkg::scan_t match_table(logic use_kw, logic ended, output int len,
                                                   output logic [7:0] ut);
        logic [tdl_pkg::CFG_W-1:0] e;
        int l;
        logic ok;
        len = 0;
        ut = 0;
        for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
            e = use_kw ? kw_tbl[i] : op_tbl[i];
            l = e[tdl_pkg::ENT_LEN_LSB +: 4];
            ok = 1'b1;
            if (l == 0) break;
            if (l > tdl_pkg::MATCH_LEN_DEF) continue;
            for (int j = 0; j < l; j++) begin
                if (j >= la_fill) begin
                    if (!ended) return tdl_pkg::SCAN_WAIT;
                    ok = 1'b0;
                    break;
                end
                if (la_win[j] != e[8*j +: 8]) begin
                    ok = 1'b0;
                    break;
                end
            end
            if (ok) begin
                len = l;
                ut = e[tdl_pkg::ENT_TYPE_LSB +: 8];
                return tdl_pkg::SCAN_HIT;
            end
        end
        return tdl_pkg::SCAN_NONE;
    endfunction

    function automatic void clear_text();
        for (int i = 0; i < WIN_D; i++) la_win[i] = 8'd0;
        la_fill = 0;
        byte_pos = 0;
        run_from = 0;
        open_run = tdl_pkg::RUN_NONE;
        pos_ovf = 1'b0;
    endfunction

    // tokens caused by one accepted byte
    function automatic void lex_byte(logic [7:0] ch, logic ended);
        logic [7:0] c, ut;
        int hp, len;
        tdl_pkg::scan_t r;
        logic cont;
        step_count = 0;
        if (byte_pos >= POS_SAT) pos_ovf = 1'b1;
        else byte_pos++;
        if (la_fill < WIN_D) la_win[la_fill++] = ch;
        while (la_fill > 0) begin
            c = la_win[0];
            hp = byte_pos >= la_fill ? byte_pos - la_fill : 0;
            if (open_run != tdl_pkg::RUN_NONE) begin
                cont = open_run == tdl_pkg::RUN_BLANK ? is_blank_c(c) :
                       open_run == tdl_pkg::RUN_IDENT ? (is_start_c(c) || is_digit_c(c)) :
                       is_digit_c(c);
                if (cont) drop_head(1);
                else close_open_run(hp);
                continue;
            end
            if (c == tdl_pkg::CH_LF) begin
                add_token(tdl_pkg::TOK_NEWLINE, hp, 1, 8'd0);
                drop_head(1);
                continue;
            end
            if (c == tdl_pkg::CH_CR) begin
                if (la_fill >= 2) len = la_win[1] == tdl_pkg::CH_LF ? 2 : 1;
                else if (ended) len = 1;
                else break;
                add_token(tdl_pkg::TOK_NEWLINE, hp, len, 8'd0);
                drop_head(len);
                continue;
            end
            if (is_blank_c(c)) begin
                open_run = tdl_pkg::RUN_BLANK;
                run_from = hp;
                drop_head(1);
                continue;
            end
            r = match_table(1'b0, ended, len, ut);
            if (r == tdl_pkg::SCAN_WAIT) break;
            if (r == tdl_pkg::SCAN_HIT) begin
                add_token(tdl_pkg::TOK_OPERATOR, hp, len, ut);
                drop_head(len);
                continue;
            end
            r = match_table(1'b1, ended, len, ut);
            if (r == tdl_pkg::SCAN_WAIT) break;
            if (r == tdl_pkg::SCAN_HIT) begin
                add_token(tdl_pkg::TOK_KEYWORD, hp, len, ut);
                drop_head(len);
                continue;
            end
            if (is_start_c(c)) begin
                open_run = tdl_pkg::RUN_IDENT;
                run_from = hp;
            end else if (is_digit_c(c)) begin
                open_run = tdl_pkg::RUN_NUMBER;
                run_from = hp;
            end
            drop_head(1);
        end
        if (ended) begin
            if (open_run != tdl_pkg::RUN_NONE) close_open_run(byte_pos);
            add_token(tdl_pkg::TOK_END, byte_pos, 0, 8'd0);
            clear_text();
        end
        if (step_count > 0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------ checking
    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // token word checker
    always @(posedge aclk) begin
        token_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tokens_seen++;
            if (token_q.size() == 0) begin
                report_mismatch("unexpected token type", m_axis_tuser, 0);
            end else begin
                w = token_q.pop_front();
                if (m_axis_tuser != w.kind) report_mismatch("token_type", m_axis_tuser, w.kind);
                if (m_axis_tdata[15:0] != w.start)
                    report_mismatch("token_start", m_axis_tdata[15:0], w.start);
                if (m_axis_tdata[31:16] != w.length)
                    report_mismatch("token_length", m_axis_tdata[31:16], w.length);
                if (m_axis_tdata[39:32] != w.utype)
                    report_mismatch("user_type", m_axis_tdata[39:32], w.utype);
                if (m_axis_tdata[40] != w.too_long)
                    report_mismatch("too_long", m_axis_tdata[40], w.too_long);
                if (m_axis_tlast != w.last) report_mismatch("tlast", m_axis_tlast, w.last);
            end
        end
    end

    // receiver stalls, long hold-off counted down here
    always @(posedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------- stimulus
    task automatic send_byte(logic [7:0] ch, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        lex_byte(ch, last);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // sender pauses until every token is out and the back end has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    function automatic logic [tdl_pkg::CFG_W-1:0] make_entry(string s, int len, logic [7:0] ut);
        logic [tdl_pkg::CFG_W-1:0] e = '0;
        for (int i = 0; i < s.len() && i < 6; i++) e[8*i +: 8] = s[i];
        e[tdl_pkg::ENT_LEN_LSB +: 4] = len[3:0];
        e[tdl_pkg::ENT_TYPE_LSB +: 8] = ut;
        return e;
    endfunction

    // writes all eight entries, block idle
    task automatic load_tables(logic [tdl_pkg::CFG_W-1:0] ops [tdl_pkg::N_ENTRIES],
                               logic [tdl_pkg::CFG_W-1:0] kws [tdl_pkg::N_ENTRIES]);
        for (int i = 0; i < 2 * tdl_pkg::N_ENTRIES; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[tdl_pkg::CFG_IDX_W-1:0];
            cfg_wdata <= i < CFG_KW0 ? ops[i] : kws[i - CFG_KW0];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
            op_tbl[i] = ops[CFG_OP0 + i];
            kw_tbl[i] = kws[i];
        end
    endtask

    task automatic load_c_like();
        logic [tdl_pkg::CFG_W-1:0] o [tdl_pkg::N_ENTRIES], k [tdl_pkg::N_ENTRIES];
        o[0] = make_entry("==", 2, 8'h01);
        o[1] = make_entry("=", 1, 8'h02);
        o[2] = make_entry("+=+=+=", 7, 8'h03);   // too long to ever match
        o[3] = make_entry("+", 1, 8'hFF);
        k[0] = make_entry("if", 2, 8'h10);
        k[1] = make_entry("while", 5, 8'h11);
        k[2] = make_entry("", 0, 8'h12);          // ends the table
        k[3] = make_entry("x", 1, 8'h13);
        load_tables(o, k);
    endtask

    task automatic load_random();
        logic [tdl_pkg::CFG_W-1:0] o [tdl_pkg::N_ENTRIES], k [tdl_pkg::N_ENTRIES];
        string abc = "=+<ia1 ";
        string s;
        int idx;
        for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
            s = "";
            for (int j = 0; j < 6; j++) begin
                idx = $urandom_range(6);
                s = {s, abc.substr(idx, idx)};
            end
            o[i] = make_entry(s, $urandom_range(1, 7), $urandom_range(255));
            s = "";
            for (int j = 0; j < 6; j++) begin
                idx = $urandom_range(6);
                s = {s, abc.substr(idx, idx)};
            end
            k[i] = make_entry(s, $urandom_range(i == 3 ? 0 : 1, 6), $urandom_range(255));
            o[i][tdl_pkg::CFG_W-1] = $urandom_range(1);
        end
        load_tables(o, k);
    endtask

    task automatic load_extreme(logic ones);
        logic [tdl_pkg::CFG_W-1:0] o [tdl_pkg::N_ENTRIES], k [tdl_pkg::N_ENTRIES];
        for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
            o[i] = ones ? '1 : '0;
            k[i] = ones ? '1 : '0;
        end
        load_tables(o, k);
    endtask

    function automatic logic [7:0] pick_byte();
        string frag = "=+<iafwhlex_9 \t";
        case ($urandom_range(9))
            0: return $urandom_range(255);
            1: return tdl_pkg::CH_CR;
            2: return tdl_pkg::CH_LF;
            3: return $urandom_range(tdl_pkg::CH_DIGIT_LO, tdl_pkg::CH_DIGIT_HI);
            4: return $urandom_range(tdl_pkg::CH_UPPER_LO, tdl_pkg::CH_LOWER_HI);
            default: return frag[$urandom_range(frag.len() - 1)];
        endcase
    endfunction

    task automatic random_texts(int n_bytes);
        int len;
        while (n_bytes > 0) begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
            n_bytes -= len;
        end
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        load_c_like();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // keyword prefix, operators, CR LF, blank run, number, skipped bytes
        send_text("ifx==+=\r\n\t 09_Z\000\377\r");
        // CR alone mid text, lone LF, text cut short inside an operator
        send_text("\rw\nwhile=");
        send_text("=");
        drain();
        load_extreme(1'b1);
        send_text("+==ab");
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 25 : 67) : 0;
            snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 25 : 67) : 0;
            case (ph)
                0: load_c_like();
                1: load_random();
                2: load_extreme(1'b0);
                default: load_random();
            endcase
            random_texts(35);
            drain();
        end
    endtask

    task automatic test_backpressure();
        load_c_like();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        snk_hold = 300;
        send_text("a==b + 12\r\n\rwhile if=\n");
        drain();
    endtask

    initial begin
        fail_count = 0;
        bytes_sent = 0;
        tokens_seen = 0;
        snk_hold = 0;
        idle_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        for (int i = 0; i < tdl_pkg::N_ENTRIES; i++) begin
            op_tbl[i] = '0;
            kw_tbl[i] = '0;
        end
        clear_text();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random();
        test_backpressure();

        $display("covered: %0d bytes, %0d tokens, table sets incl. empty, full-ones and random",
                 bytes_sent, tokens_seen);
        $display("idle mixes on both sides and a long receiver hold-off that fills the block");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tdl_pkg.sv
hdl/tdl_fifo.sv
hdl/tdl_front.sv
hdl/tdl_back.sv
hdl/table_driven_lexer.sv
bench/tb_top.sv
